// File: sv/mac_data_header_builder_assert.svh
// Assertion macros for the MAC data header builder.
`ifndef MAC_DATA_HEADER_BUILDER_ASSERT_SVH
`define MAC_DATA_HEADER_BUILDER_ASSERT_SVH

`ifndef SYNTHESIS
`define MDHB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("mdhb assertion failed");
`define MDHB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mdhb assertion failed");
`else
`define MDHB_ASSERT(lbl, clk, rstn, prop)
`define MDHB_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: sv/mdhb_pkg.sv
// Types, constants and helper functions shared by the MAC data header builder.
package mdhb_pkg;

  typedef enum logic [1:0] {
    ModeNone     = 2'd0,
    ModeReserved = 2'd1,
    ModeShort    = 2'd2,
    ModeLong     = 2'd3
  } addr_mode_e;

  typedef logic [4:0] pos_t;

  localparam logic [2:0] FrameTypeData = 3'd1;
  localparam logic [1:0] FrameVersion  = 2'd0;

  // Fixed byte positions at the head of every header.
  localparam pos_t FcLoPos   = 5'd0;
  localparam pos_t FcHiPos   = 5'd1;
  localparam pos_t SeqPos    = 5'd2;
  localparam pos_t DstPanPos = 5'd3;

  localparam pos_t PanLen = 5'd2;

  typedef struct packed {
    addr_mode_e  src_mode;
    addr_mode_e  dst_mode;
    logic        src_pan_given;
    logic [15:0] src_pan_id;
    logic        dst_pan_given;
    logic [15:0] dst_pan_id;
    logic [63:0] src_address;
    logic [63:0] dst_address;
    logic        ack_request;
    logic [7:0]  room;
  } req_t;

  typedef struct packed {
    logic [15:0] fc;
    pos_t        dst_addr_pos;
    pos_t        src_pan_pos;
    pos_t        src_addr_pos;
    pos_t        total;
    logic        too_small;
  } layout_t;

  function automatic pos_t addr_len(addr_mode_e mode);
    pos_t len;
    case (mode)
      ModeShort: len = 5'd2;
      ModeLong:  len = 5'd8;
      default:   len = 5'd0;
    endcase
    return len;
  endfunction

  // Short addresses go low byte first, long addresses most significant first.
  function automatic logic [7:0] addr_byte(addr_mode_e mode, logic [63:0] addr,
                                           logic [2:0] off);
    logic [2:0] sel;
    if (mode == ModeLong) begin
      sel = ~off;
    end else begin
      sel = {2'b00, off[0]};
    end
    return addr[{sel, 3'b000} +: 8];
  endfunction

endpackage

// File: sv/mdhb_layout.sv
// Works out frame control, PAN compression and the byte layout of one header.
module mdhb_layout (
  input  mdhb_pkg::req_t    req_i,
  output mdhb_pkg::layout_t layout_o
);

  logic           compress;
  logic           src_pan_sent;
  mdhb_pkg::pos_t dst_addr_pos;
  mdhb_pkg::pos_t src_pan_pos;
  mdhb_pkg::pos_t src_addr_pos;
  mdhb_pkg::pos_t total;

  // A reserved mode still counts as an address being present here.
  assign compress = req_i.src_pan_given && req_i.dst_pan_given
                 && (req_i.src_mode != mdhb_pkg::ModeNone)
                 && (req_i.dst_mode != mdhb_pkg::ModeNone)
                 && (req_i.src_pan_id == req_i.dst_pan_id);

  assign src_pan_sent = req_i.src_pan_given && !compress;

  assign dst_addr_pos = mdhb_pkg::DstPanPos
                      + (req_i.dst_pan_given ? mdhb_pkg::PanLen : 5'd0);
  assign src_pan_pos  = dst_addr_pos + mdhb_pkg::addr_len(req_i.dst_mode);
  assign src_addr_pos = src_pan_pos + (src_pan_sent ? mdhb_pkg::PanLen : 5'd0);
  assign total        = src_addr_pos + mdhb_pkg::addr_len(req_i.src_mode);

  assign layout_o.fc           = {req_i.src_mode, mdhb_pkg::FrameVersion, req_i.dst_mode,
                                  3'b000, compress, req_i.ack_request, 2'b00,
                                  mdhb_pkg::FrameTypeData};
  assign layout_o.dst_addr_pos = dst_addr_pos;
  assign layout_o.src_pan_pos  = src_pan_pos;
  assign layout_o.src_addr_pos = src_addr_pos;
  assign layout_o.total        = total;
  assign layout_o.too_small    = req_i.room < {3'b000, total};

endmodule

// File: sv/mdhb_byte_sel.sv
// Picks the header byte at a given position from the held request.
module mdhb_byte_sel (
  input  mdhb_pkg::req_t    req_i,
  input  mdhb_pkg::layout_t layout_i,
  input  mdhb_pkg::pos_t    idx_i,
  output logic [7:0]        byte_o
);

  mdhb_pkg::pos_t off_dpan;
  mdhb_pkg::pos_t off_daddr;
  mdhb_pkg::pos_t off_span;
  mdhb_pkg::pos_t off_saddr;

  assign off_dpan  = idx_i - mdhb_pkg::DstPanPos;
  assign off_daddr = idx_i - layout_i.dst_addr_pos;
  assign off_span  = idx_i - layout_i.src_pan_pos;
  assign off_saddr = idx_i - layout_i.src_addr_pos;

  always_comb begin
    if (idx_i == mdhb_pkg::FcLoPos) begin
      byte_o = layout_i.fc[7:0];
    end else if (idx_i == mdhb_pkg::FcHiPos) begin
      byte_o = layout_i.fc[15:8];
    end else if (idx_i == mdhb_pkg::SeqPos) begin
      byte_o = 8'h00;
    end else if (idx_i < layout_i.dst_addr_pos) begin
      byte_o = off_dpan[0] ? req_i.dst_pan_id[15:8] : req_i.dst_pan_id[7:0];
    end else if (idx_i < layout_i.src_pan_pos) begin
      byte_o = mdhb_pkg::addr_byte(req_i.dst_mode, req_i.dst_address, off_daddr[2:0]);
    end else if (idx_i < layout_i.src_addr_pos) begin
      byte_o = off_span[0] ? req_i.src_pan_id[15:8] : req_i.src_pan_id[7:0];
    end else begin
      byte_o = mdhb_pkg::addr_byte(req_i.src_mode, req_i.src_address, off_saddr[2:0]);
    end
  end

endmodule

// File: sv/mac_data_header_builder.sv
// Top level of the MAC data header builder: request hold, byte walker and result register.
//
//   channel   handshake                  payload
//   request   in_valid_i / in_ready_o    src_mode_i .. room_i
//   result    out_valid_o / out_ready_i  out_byte_o, last_o, too_small_o, hdr_len_o
//
// A request is held in the request register and walked one header byte per cycle
// into the result register while the result is not stalled, so a header of 3 to 23
// bytes gives one result per byte, and a request with too little room gives a single
// error result. The next request is taken in the cycle that the last byte is issued,
// so headers follow each other with no gap. After a transfer, the request is held in
// the request register and its first byte then goes into the result register. Reset
// clears the hold, the byte counter and the result valid; a stalled result holds its byte and stops the walk.
module mac_data_header_builder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  src_mode_i,
  input  logic [1:0]  dst_mode_i,
  input  logic        src_pan_given_i,
  input  logic [15:0] src_pan_id_i,
  input  logic        dst_pan_given_i,
  input  logic [15:0] dst_pan_id_i,
  input  logic [63:0] src_address_i,
  input  logic [63:0] dst_address_i,
  input  logic        ack_request_i,
  input  logic [7:0]  room_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic        too_small_o,
  output logic [4:0]  hdr_len_o
);

  mdhb_pkg::req_t    req_d, req_q;
  mdhb_pkg::layout_t layout;
  mdhb_pkg::pos_t    idx_d, idx_q;
  logic              busy_d, busy_q;
  logic [7:0]        sel_byte;
  logic              out_free;
  logic              emit;
  logic              sel_last;
  logic              in_xfer;

  logic              out_valid_d, out_valid_q;
  logic [7:0]        out_byte_d, out_byte_q;
  logic              last_d, last_q;
  logic              too_small_d, too_small_q;
  logic [4:0]        hdr_len_d, hdr_len_q;

  mdhb_layout u_layout (
    .req_i    (req_q),
    .layout_o (layout)
  );

  mdhb_byte_sel u_byte_sel (
    .req_i    (req_q),
    .layout_i (layout),
    .idx_i    (idx_q),
    .byte_o   (sel_byte)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign emit       = busy_q && out_free;
  assign sel_last   = layout.too_small || (idx_q == layout.total - 5'd1);
  assign in_ready_o = !busy_q || (out_free && sel_last);
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    req_d.src_mode      = mdhb_pkg::addr_mode_e'(src_mode_i);
    req_d.dst_mode      = mdhb_pkg::addr_mode_e'(dst_mode_i);
    req_d.src_pan_given = src_pan_given_i;
    req_d.src_pan_id    = src_pan_id_i;
    req_d.dst_pan_given = dst_pan_given_i;
    req_d.dst_pan_id    = dst_pan_id_i;
    req_d.src_address   = src_address_i;
    req_d.dst_address   = dst_address_i;
    req_d.ack_request   = ack_request_i;
    req_d.room          = room_i;
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (emit) begin
      idx_d = sel_last ? 5'd0 : idx_q + 5'd1;
      if (sel_last) begin
        busy_d = 1'b0;
      end
    end
    if (in_xfer) begin
      busy_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    last_d      = last_q;
    too_small_d = too_small_q;
    hdr_len_d   = hdr_len_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = layout.too_small ? 8'h00 : sel_byte;
      last_d      = sel_last;
      too_small_d = layout.too_small;
      hdr_len_d   = layout.too_small ? 5'd0 : layout.total;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q <= req_d;
    end
    out_byte_q  <= out_byte_d;
    last_q      <= last_d;
    too_small_q <= too_small_d;
    hdr_len_q   <= hdr_len_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;
  assign too_small_o = too_small_q;
  assign hdr_len_o   = hdr_len_q;

`include "mac_data_header_builder_assert.svh"

  // The counter rests at zero whenever no request is held.
  `MDHB_ASSERT_ALWAYS(a_idle_idx_zero, clk_i, !busy_q |-> (idx_q == 5'd0))
  // The walk never runs past the end of the header.
  `MDHB_ASSERT(a_idx_in_range, clk_i, rst_ni,
               (busy_q && !layout.too_small) |-> (idx_q < layout.total))
  // A transfer while a request is held lines up with that request's last result.
  `MDHB_ASSERT(a_overlap_on_last, clk_i, rst_ni,
               (in_xfer && busy_q) |=> (out_valid_q && last_q))
  // An error result is always a single, final result.
  `MDHB_ASSERT(a_error_is_last, clk_i, rst_ni,
               (out_valid_q && too_small_q) |-> (last_q && (hdr_len_q == 5'd0)))

endmodule
